// File: hw/rtl/psqe_pkg.sv
// Shared types and constants for the polyline stroke quad expander.
package psqe_pkg;

  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  // magnitudes are brought below 2^MAG_BITS before squaring
  localparam int MAG_BITS   = 15;
  localparam int ROOT_BITS  = 32;
  localparam int ROOT_STEPS = 32;

  typedef struct packed {
    logic       capture;
    logic       commit;
    logic       shift;
    logic       square;
    logic       root_init;
    logic       root_step;
    logic       div_init;
    logic       div_step;
    logic       out_load;
    logic       out_clear;
    logic [1:0] out_sel;
  } cmd_t;

  typedef struct packed {
    logic clear_req;
    logic is_start;
    logic seg_zero;
    logic shift_more;
    logic out_free;
  } sts_t;

endpackage

// File: hw/rtl/psqe_ctrl.sv
// Sequencer for the quad expander: decode, normalize, square, root, divide, emit, clear.
module psqe_ctrl #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  psqe_pkg::sts_t  sts,
  output psqe_pkg::cmd_t  cmd
);

  localparam int DIV_CW = $clog2(NORMAL_FRAC_BITS + 1);
  localparam int ROOT_CW = $clog2(psqe_pkg::ROOT_STEPS);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_NORM, S_SQUARE, S_ROOT_INIT, S_ROOT,
    S_DIV_INIT, S_DIV, S_EMIT, S_CLEAR
  } state_t;

  state_t              state;
  logic [ROOT_CW-1:0]  root_cnt;
  logic [DIV_CW-1:0]   div_cnt;
  logic [1:0]          emit_idx;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.out_sel   = emit_idx;
    cmd.capture   = (state == S_IDLE) && in_valid;
    cmd.shift     = (state == S_NORM) && sts.shift_more;
    cmd.square    = (state == S_SQUARE);
    cmd.root_init = (state == S_ROOT_INIT);
    cmd.root_step = (state == S_ROOT);
    cmd.div_init  = (state == S_DIV_INIT);
    cmd.div_step  = (state == S_DIV);
    case (state)
      S_DECODE: begin
        cmd.commit = !sts.clear_req && sts.is_start;
      end
      S_EMIT: begin
        cmd.out_load = sts.out_free;
        cmd.commit   = sts.out_free && (emit_idx == 2'd3);
      end
      S_CLEAR: begin
        cmd.out_load  = sts.out_free;
        cmd.out_clear = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      root_cnt <= '0;
      div_cnt  <= '0;
      emit_idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DECODE;
        end
        S_DECODE: begin
          emit_idx <= '0;
          if (sts.clear_req) state <= S_CLEAR;
          else if (sts.is_start) state <= S_IDLE;
          else if (sts.seg_zero) state <= S_EMIT;
          else state <= S_NORM;
        end
        S_NORM: begin
          if (!sts.shift_more) state <= S_SQUARE;
        end
        S_SQUARE: begin
          state <= S_ROOT_INIT;
        end
        S_ROOT_INIT: begin
          root_cnt <= '0;
          state    <= S_ROOT;
        end
        S_ROOT: begin
          root_cnt <= root_cnt + 1'b1;
          if (root_cnt == ROOT_CW'(psqe_pkg::ROOT_STEPS - 1)) state <= S_DIV_INIT;
        end
        S_DIV_INIT: begin
          div_cnt <= DIV_CW'(NORMAL_FRAC_BITS);
          state   <= S_DIV;
        end
        S_DIV: begin
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == '0) state <= S_EMIT;
        end
        S_EMIT: begin
          if (sts.out_free) begin
            emit_idx <= emit_idx + 1'b1;
            if (emit_idx == 2'd3) state <= S_IDLE;
          end
        end
        S_CLEAR: begin
          if (sts.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/psqe_dp.sv
// Datapath: last point, segment magnitudes, root and divide units, output word.
module psqe_dp #(
  parameter int COORD_BITS       = 16,
  parameter int NORMAL_FRAC_BITS = 14,
  parameter int IN_W             = 32,
  parameter int OUT_W            = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  psqe_pkg::cmd_t       cmd,
  output psqe_pkg::sts_t       sts,
  input  logic [IN_W-1:0]      in_data,
  input  logic [1:0]           in_user,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_W-1:0]     out_data,
  output logic                 out_user,
  output logic                 out_last
);

  localparam int CB  = COORD_BITS;
  localparam int F   = NORMAL_FRAC_BITS;
  localparam int NB  = F + 2;
  localparam int MW  = CB + 1;
  localparam int MB  = psqe_pkg::MAG_BITS;
  localparam int RB  = psqe_pkg::ROOT_BITS;
  localparam int NW  = F + 2 * MB + 2;
  localparam int QW  = F + 1;

  logic [1:0]          req;
  logic [CB-1:0]       px, py, prev_x, prev_y;
  logic                dx_pos, dy_neg;
  logic [MW-1:0]       ax, ay;
  logic [2*MB-1:0]     sq_x, sq_y;
  logic [RB-1:0]       rad, root;
  logic [RB+1:0]       rem_s;
  logic [RB-1:0]       rem_x, rem_y;
  logic [QW-1:0]       q_x, q_y;

  logic signed [MW-1:0] dx_c, dy_c;
  logic [MB-1:0]        ax15, ay15;
  logic [RB+3:0]        rs, tr;
  logic [NW-1:0]        num_x, num_y;
  logic [RB:0]          tx, ty, rr;
  logic                 gex, gey;
  logic [QW-1:0]        sat_x, sat_y;
  logic signed [NB-1:0] nx, ny, nxo, nyo;
  logic [CB-1:0]        vx, vy;

  always_comb begin
    dx_c  = MW'($signed(in_data[CB-1:0]))    - MW'($signed(prev_x));
    dy_c  = MW'($signed(in_data[2*CB-1:CB])) - MW'($signed(prev_y));
    ax15  = MB'(ax);
    ay15  = MB'(ay);
    rs    = {rem_s, rad[RB-1:RB-2]};
    tr    = {2'b00, root, 2'b01};
    num_x = (NW'(ay15) << (F + 2 * MB + 1 - MB)) + NW'(root >> 1);
    num_y = (NW'(ax15) << (F + 2 * MB + 1 - MB)) + NW'(root >> 1);
    rr    = {1'b0, root};
    tx    = {rem_x, q_x[QW-1]};
    ty    = {rem_y, q_y[QW-1]};
    gex   = (tx >= rr);
    gey   = (ty >= rr);
    sat_x = (q_x > QW'(1 << F)) ? QW'(1 << F) : q_x;
    sat_y = (q_y > QW'(1 << F)) ? QW'(1 << F) : q_y;
    nx    = dy_neg ? -NB'(sat_x) : NB'(sat_x);
    ny    = dx_pos ? -NB'(sat_y) : NB'(sat_y);
    if (sts.seg_zero) begin
      nx = '0;
      ny = '0;
    end
    nxo = cmd.out_sel[0] ? nx : -nx;
    nyo = cmd.out_sel[0] ? ny : -ny;
    vx  = cmd.out_sel[1] ? px : prev_x;
    vy  = cmd.out_sel[1] ? py : prev_y;
  end

  always_comb begin
    sts.clear_req  = (req & psqe_pkg::REQ_CLEAR) != '0;
    sts.is_start   = (req == psqe_pkg::REQ_START);
    sts.seg_zero   = (ax == '0) && (ay == '0);
    sts.shift_more = ((ax >> MB) != '0) || ((ay >> MB) != '0);
    sts.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
    end else if (cmd.commit) begin
      prev_x <= px;
      prev_y <= py;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req    <= in_user;
      px     <= in_data[CB-1:0];
      py     <= in_data[2*CB-1:CB];
      dx_pos <= dx_c > 0;
      dy_neg <= dy_c < 0;
      ax     <= (dx_c < 0) ? MW'(-dx_c) : MW'(dx_c);
      ay     <= (dy_c < 0) ? MW'(-dy_c) : MW'(dy_c);
    end else if (cmd.shift) begin
      ax <= ax >> 1;
      ay <= ay >> 1;
    end
    if (cmd.square) begin
      sq_x <= ax15 * ax15;
      sq_y <= ay15 * ay15;
    end
    if (cmd.root_init) begin
      rad   <= RB'(sq_x) + RB'(sq_y);
      rem_s <= '0;
      root  <= '0;
    end else if (cmd.root_step) begin
      rad <= {rad[RB-3:0], 2'b00};
      if (rs >= tr) begin
        rem_s <= (RB+2)'(rs - tr);
        root  <= {root[RB-2:0], 1'b1};
      end else begin
        rem_s <= (RB+2)'(rs);
        root  <= {root[RB-2:0], 1'b0};
      end
    end
    if (cmd.div_init) begin
      rem_x <= RB'(num_x >> QW);
      rem_y <= RB'(num_y >> QW);
      q_x   <= num_x[QW-1:0];
      q_y   <= num_y[QW-1:0];
    end else if (cmd.div_step) begin
      rem_x <= gex ? RB'(tx - rr) : RB'(tx);
      rem_y <= gey ? RB'(ty - rr) : RB'(ty);
      q_x   <= {q_x[QW-2:0], gex};
      q_y   <= {q_y[QW-2:0], gey};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_clear) begin
        out_data <= '0;
        out_user <= psqe_pkg::KIND_CLEAR;
        out_last <= 1'b1;
      end else begin
        out_data <= OUT_W'({nyo, nxo, vy, vx});
        out_user <= psqe_pkg::KIND_VERTEX;
        out_last <= (cmd.out_sel == 2'd3);
      end
    end
  end

endmodule

// File: hw/rtl/polyline_stroke_quad_expander.sv
// Top level of the polyline stroke quad expander.
//
// Input stream s_axis: s_axis_tuser is the request (further point, stroke
// start, clear), s_axis_tdata carries the point. A stroke start stores the
// point and emits nothing. A further point emits four triangle-strip words
// on m_axis: (last,-n) (last,+n) (new,-n) (new,+n), tlast on the fourth, n
// being the unit normal of the segment in Q2.NORMAL_FRAC_BITS. A clear emits
// one marker word (tuser set, data zero, tlast set).
// One item is in flight at a time; s_axis_tready is high only when idle.
// Before squaring, both deltas are halved until they lie below 2^15. The
// square root is a 32-step digit-by-digit unit and the dividers produce
// one quotient bit per cycle. A zero-length segment skips the math.
// The output word is registered; a stalled receiver holds the sequencer in
// its emit step, and the last word may still wait when the next item enters.
// Synchronous reset clears the last point to zero and empties the output.
module polyline_stroke_quad_expander #(
  parameter int COORD_BITS       = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [((2 * COORD_BITS + 7) / 8) * 8 - 1:0]
                            s_axis_tdata,   // point_x, point_y
  input  logic [1:0]        s_axis_tuser,   // req_type
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [((2 * COORD_BITS + 2 * (NORMAL_FRAC_BITS + 2) + 7) / 8) * 8 - 1:0]
                            m_axis_tdata,   // vertex_x, vertex_y, normal_x, normal_y
  output logic              m_axis_tuser,   // item_kind
  output logic              m_axis_tlast    // last_of_run
);

  localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((2 * COORD_BITS + 2 * (NORMAL_FRAC_BITS + 2) + 7) / 8) * 8;

  psqe_pkg::cmd_t cmd;
  psqe_pkg::sts_t sts;

  psqe_ctrl #(
    .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  psqe_dp #(
    .COORD_BITS       (COORD_BITS),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
    .IN_W             (IN_W),
    .OUT_W            (OUT_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

// File: hw/rtl/psqe_checker.sv
// Port-level checks for the quad expander, bound to the top level.
module psqe_checker #(
  parameter int OUT_W = 64
) (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tuser,
  input logic             m_axis_tlast
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a word was in progress");

  a_clear_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == psqe_pkg::KIND_CLEAR) |-> m_axis_tlast)
    else $error("clear marker without tlast");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == psqe_pkg::KIND_CLEAR) |-> (m_axis_tdata == '0))
    else $error("clear marker carries data");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output word changed");

endmodule

bind polyline_stroke_quad_expander psqe_checker #(
  .OUT_W(OUT_W)
) u_psqe_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
